// ----- rtl/ioexp_pkg.sv -----
// Shared types and constants for the two-port I/O expander with key latch.
package ioexp_pkg;

    typedef enum logic [2:0] {
        ACT_START   = 3'd0,
        ACT_WRITE   = 3'd1,
        ACT_READ    = 3'd2,
        ACT_PIN     = 3'd3,
        ACT_KEY     = 3'd4,
        ACT_RELEASE = 3'd5
    } t_action;

    // Register kind from pointer bits [2:1]; bit 0 selects the port.
    typedef enum logic [1:0] {
        KIND_INPUT    = 2'd0,
        KIND_LATCH    = 2'd1,
        KIND_POLARITY = 2'd2,
        KIND_DIRECTION = 2'd3
    } t_reg_kind;

    localparam logic CFG_KEY_PORT = 1'b0;
    localparam logic CFG_KEY_BIT  = 1'b1;

    localparam logic [2:0] PTR_MASK  = 3'h7;
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef struct packed {
        logic       key_pressed;
        logic       pin_level;
        logic [2:0] pin_bit;
        logic       pin_port;
        logic [7:0] data_byte;
        logic [2:0] action;
    } t_in_item;

    typedef struct packed {
        logic [7:0] drive_high_port1;
        logic [7:0] drive_high_port0;
        logic       status;
        logic [7:0] read_data;
    } t_out_item;

    // Pin value: external level on input bits, latch on output bits, then polarity.
    function automatic logic [7:0] pin_value(input logic [7:0] ext, input logic [7:0] latch,
                                             input logic [7:0] dir, input logic [7:0] pol);
        pin_value = ((ext & dir) | (latch & ~dir)) ^ pol;
    endfunction

endpackage

// ----- rtl/io_expander_with_key_latch.sv -----
// Top level: two-port I/O expander register file with latched function key.
// A request is registered on accept; its result is registered when the result
// register is free or being taken. Throughput: one request per cycle while
// the result side takes results; state update and register read are a single
// pass of logic between input and result registers. Reset (synchronous,
// active low) restores all but the payload registers to power-on values.
module io_expander_with_key_latch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: data_byte[7:0], pin_port[8], pin_bit[11:9], pin_level[12],
    //        key_pressed[13], zero[15:14]
    input  logic [15:0] i_s_tdata,
    // tuser: action[2:0]
    input  logic [2:0]  i_s_tuser,
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: read_data[7:0], drive_high_port0[15:8], drive_high_port1[23:16]
    output logic [23:0] o_m_tdata,
    // tuser: status[0]
    output logic        o_m_tuser,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic                  r_in_valid;
    ioexp_pkg::t_in_item   r_in;
    logic                  r_out_valid;
    ioexp_pkg::t_out_item  r_out;
    ioexp_pkg::t_out_item  n_out;
    logic                  advance;

    logic       r_key_port;
    logic [2:0] r_key_bit;

    logic [7:0] r_ext0, r_ext1, n_ext0, n_ext1;
    logic [7:0] r_lat0, r_lat1, n_lat0, n_lat1;
    logic [7:0] r_pol0, r_pol1, n_pol0, n_pol1;
    logic [7:0] r_dir0, r_dir1, n_dir0, n_dir1;
    logic [2:0] r_ptr, n_ptr;
    logic       r_expect_ptr, n_expect_ptr;
    logic       r_press_unread, n_press_unread;
    logic       r_rel_deferred, n_rel_deferred;

    logic                  port;
    ioexp_pkg::t_reg_kind  kind;
    logic [7:0]            key_mask;
    logic [7:0]            pin_mask;
    logic [7:0]            rd;
    logic                  status;

    assign advance     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {r_out.drive_high_port1, r_out.drive_high_port0, r_out.read_data};
    assign o_m_tuser   = r_out.status;

    assign port     = r_ptr[0];
    assign kind     = ioexp_pkg::t_reg_kind'(r_ptr[2:1]);
    assign key_mask = 8'b1 << r_key_bit;
    assign pin_mask = 8'b1 << r_in.pin_bit;

    always_comb begin
        n_ext0         = r_ext0;
        n_ext1         = r_ext1;
        n_lat0         = r_lat0;
        n_lat1         = r_lat1;
        n_pol0         = r_pol0;
        n_pol1         = r_pol1;
        n_dir0         = r_dir0;
        n_dir1         = r_dir1;
        n_ptr          = r_ptr;
        n_expect_ptr   = r_expect_ptr;
        n_press_unread = r_press_unread;
        n_rel_deferred = r_rel_deferred;
        rd             = 8'h00;
        status         = 1'b0;

        case (ioexp_pkg::t_action'(r_in.action))
            ioexp_pkg::ACT_START: begin
                n_expect_ptr = 1'b1;
            end
            ioexp_pkg::ACT_WRITE: begin
                if (r_expect_ptr) begin
                    n_ptr        = r_in.data_byte[2:0] & ioexp_pkg::PTR_MASK;
                    n_expect_ptr = 1'b0;
                end else begin
                    case (kind)
                        ioexp_pkg::KIND_LATCH: begin
                            if (port) n_lat1 = r_in.data_byte;
                            else      n_lat0 = r_in.data_byte;
                        end
                        ioexp_pkg::KIND_POLARITY: begin
                            if (port) n_pol1 = r_in.data_byte;
                            else      n_pol0 = r_in.data_byte;
                        end
                        ioexp_pkg::KIND_DIRECTION: begin
                            if (port) n_dir1 = r_in.data_byte;
                            else      n_dir0 = r_in.data_byte;
                        end
                        default: begin
                            // input registers are read only
                            status = 1'b1;
                        end
                    endcase
                    n_ptr = r_ptr + 3'd1;
                end
            end
            ioexp_pkg::ACT_READ: begin
                case (kind)
                    ioexp_pkg::KIND_INPUT: begin
                        rd = port ? ioexp_pkg::pin_value(r_ext1, r_lat1, r_dir1, r_pol1)
                                  : ioexp_pkg::pin_value(r_ext0, r_lat0, r_dir0, r_pol0);
                    end
                    ioexp_pkg::KIND_LATCH:     rd = port ? r_lat1 : r_lat0;
                    ioexp_pkg::KIND_POLARITY:  rd = port ? r_pol1 : r_pol0;
                    default:                   rd = port ? r_dir1 : r_dir0;
                endcase
                // reading the key's input register clears the press
                if (r_ptr == {2'b00, r_key_port} && r_press_unread) begin
                    n_press_unread = 1'b0;
                    if (r_rel_deferred) begin
                        n_rel_deferred = 1'b0;
                        if (r_key_port) n_ext1 = r_ext1 | key_mask;
                        else            n_ext0 = r_ext0 | key_mask;
                    end
                end
                n_ptr = r_ptr + 3'd1;
            end
            ioexp_pkg::ACT_PIN: begin
                if (r_in.pin_port) begin
                    n_ext1 = r_in.pin_level ? (r_ext1 | pin_mask) : (r_ext1 & ~pin_mask);
                end else begin
                    n_ext0 = r_in.pin_level ? (r_ext0 | pin_mask) : (r_ext0 & ~pin_mask);
                end
            end
            ioexp_pkg::ACT_KEY: begin
                if (r_in.key_pressed) begin
                    n_press_unread = 1'b1;
                    n_rel_deferred = 1'b0;
                    if (r_key_port) n_ext1 = r_ext1 & ~key_mask;
                    else            n_ext0 = r_ext0 & ~key_mask;
                end else if (r_press_unread) begin
                    // hold the key low until its register is read
                    n_rel_deferred = 1'b1;
                end else begin
                    if (r_key_port) n_ext1 = r_ext1 | key_mask;
                    else            n_ext0 = r_ext0 | key_mask;
                end
            end
            ioexp_pkg::ACT_RELEASE: begin
                n_ext0 = ioexp_pkg::BYTE_ONES;
                n_ext1 = ioexp_pkg::BYTE_ONES;
            end
            default: begin
            end
        endcase

        n_out.read_data        = rd;
        n_out.status           = status;
        n_out.drive_high_port0 = n_lat0 & ~n_dir0;
        n_out.drive_high_port1 = n_lat1 & ~n_dir1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_key_port     <= 1'b0;
            r_key_bit      <= 3'd0;
            r_ext0         <= ioexp_pkg::BYTE_ONES;
            r_ext1         <= ioexp_pkg::BYTE_ONES;
            r_lat0         <= ioexp_pkg::BYTE_ONES;
            r_lat1         <= ioexp_pkg::BYTE_ONES;
            r_pol0         <= 8'h00;
            r_pol1         <= 8'h00;
            r_dir0         <= ioexp_pkg::BYTE_ONES;
            r_dir1         <= ioexp_pkg::BYTE_ONES;
            r_ptr          <= 3'd0;
            r_expect_ptr   <= 1'b1;
            r_press_unread <= 1'b0;
            r_rel_deferred <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ioexp_pkg::CFG_KEY_PORT: r_key_port <= i_cfg_data[0];
                    ioexp_pkg::CFG_KEY_BIT:  r_key_bit  <= i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid    <= 1'b1;
                r_ext0         <= n_ext0;
                r_ext1         <= n_ext1;
                r_lat0         <= n_lat0;
                r_lat1         <= n_lat1;
                r_pol0         <= n_pol0;
                r_pol1         <= n_pol1;
                r_dir0         <= n_dir0;
                r_dir1         <= n_dir1;
                r_ptr          <= n_ptr;
                r_expect_ptr   <= n_expect_ptr;
                r_press_unread <= n_press_unread;
                r_rel_deferred <= n_rel_deferred;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.action      <= i_s_tuser;
            r_in.data_byte   <= i_s_tdata[7:0];
            r_in.pin_port    <= i_s_tdata[8];
            r_in.pin_bit     <= i_s_tdata[11:9];
            r_in.pin_level   <= i_s_tdata[12];
            r_in.key_pressed <= i_s_tdata[13];
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the two-port I/O expander with function key latch.
`timescale 1ns / 1ps

module tb_top;

    // Action codes beyond the defined set; the block must answer them as no-ops.
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    localparam int unsigned STALL_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] rd;
        logic       st;
        logic [7:0] dh0;
        logic [7:0] dh1;
    } t_io_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [15:0] s_data = '0;
    logic [2:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_cfg_ready;

    io_expander_with_key_latch dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Expander state as the block should hold it.
    logic [7:0] ext_lvl [2];
    logic [7:0] latch [2];
    logic [7:0] pol [2];
    logic [7:0] dir_in [2];
    logic [2:0] ptr;
    logic       want_ptr;
    logic       key_unread;
    logic       rel_pending;
    logic       key_port_q;
    logic [2:0] key_pos_q;

    t_io_result  expected_results [$];
    int unsigned errors = 0;
    int unsigned reqs_sent = 0;
    int unsigned key_events = 0;
    int unsigned results_checked = 0;
    int unsigned settings_done = 0;
    int unsigned idle_cycles = 0;

    // Sender and receiver pacing.
    bit          gaps_on = 1'b0;
    int unsigned burst_left = 0;
    bit          rx_stall_on = 1'b0;
    int unsigned rx_hold_req = 0;
    int unsigned rx_hold_left = 0;
    bit          rx_holding = 1'b0;
    logic [15:0] rx_pattern = 16'hB5A3;
    logic        cur_key_port = 1'b0;
    logic [2:0]  cur_key_pos = 3'd0;

    function automatic void clear_model();
        ext_lvl     = '{ioexp_pkg::BYTE_ONES, ioexp_pkg::BYTE_ONES};
        latch       = '{ioexp_pkg::BYTE_ONES, ioexp_pkg::BYTE_ONES};
        pol         = '{8'h00, 8'h00};
        dir_in      = '{ioexp_pkg::BYTE_ONES, ioexp_pkg::BYTE_ONES};
        ptr         = '0;
        want_ptr    = 1'b1;
        key_unread  = 1'b0;
        rel_pending = 1'b0;
        key_port_q  = 1'b0;
        key_pos_q   = '0;
    endfunction

    // Apply one request to the model and return the result it must produce.
    function automatic t_io_result apply_request(input logic [2:0] act, input logic [15:0] word);
        t_io_result           r;
        ioexp_pkg::t_reg_kind kind;
        logic                 p;
        logic [7:0]           d;
        r = '0;
        d = word[7:0];
        kind = ioexp_pkg::t_reg_kind'(ptr[2:1]);
        p = ptr[0];
        case (act)
            ioexp_pkg::ACT_START: want_ptr = 1'b1;
            ioexp_pkg::ACT_WRITE: begin
                if (want_ptr) begin
                    ptr = d[2:0] & ioexp_pkg::PTR_MASK;
                    want_ptr = 1'b0;
                end else begin
                    case (kind)
                        ioexp_pkg::KIND_INPUT:    r.st = 1'b1;
                        ioexp_pkg::KIND_LATCH:    latch[p] = d;
                        ioexp_pkg::KIND_POLARITY: pol[p] = d;
                        default:                  dir_in[p] = d;
                    endcase
                    ptr = (ptr + 3'd1) & ioexp_pkg::PTR_MASK;
                end
            end
            ioexp_pkg::ACT_READ: begin
                case (kind)
                    ioexp_pkg::KIND_INPUT:
                        r.rd = ((ext_lvl[p] & dir_in[p]) | (latch[p] & ~dir_in[p])) ^ pol[p];
                    ioexp_pkg::KIND_LATCH:    r.rd = latch[p];
                    ioexp_pkg::KIND_POLARITY: r.rd = pol[p];
                    default:                  r.rd = dir_in[p];
                endcase
                // Reading the key's input register acknowledges the press.
                if (ptr == {2'b00, key_port_q} && key_unread) begin
                    key_unread = 1'b0;
                    if (rel_pending) begin
                        rel_pending = 1'b0;
                        ext_lvl[key_port_q][key_pos_q] = 1'b1;
                    end
                end
                ptr = (ptr + 3'd1) & ioexp_pkg::PTR_MASK;
            end
            ioexp_pkg::ACT_PIN: ext_lvl[word[8]][word[11:9]] = word[12];
            ioexp_pkg::ACT_KEY: begin
                if (word[13]) begin
                    key_unread = 1'b1;
                    rel_pending = 1'b0;
                    ext_lvl[key_port_q][key_pos_q] = 1'b0;
                end else if (key_unread) begin
                    rel_pending = 1'b1;
                end else begin
                    ext_lvl[key_port_q][key_pos_q] = 1'b1;
                end
            end
            ioexp_pkg::ACT_RELEASE: ext_lvl = '{ioexp_pkg::BYTE_ONES, ioexp_pkg::BYTE_ONES};
            default: ;
        endcase
        r.dh0 = latch[0] & ~dir_in[0];
        r.dh1 = latch[1] & ~dir_in[1];
        return r;
    endfunction

    function automatic void note_mismatch(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        errors++;
        if (errors <= 30)
            $display("%0t: %s mismatch, expected %02h, got %02h", $time, field, want, got);
    endfunction

    // Track config writes, predict accepted requests, check results, watch for hangs.
    always @(posedge i_clk) begin
        t_io_result want;
        t_io_result got;
        if (!i_rst_n) begin
            clear_model();
            idle_cycles = 0;
        end else begin
            if (cfg_valid && o_cfg_ready) begin
                case (cfg_index)
                    ioexp_pkg::CFG_KEY_PORT: key_port_q = cfg_data[0];
                    ioexp_pkg::CFG_KEY_BIT:  key_pos_q = cfg_data[2:0];
                    default: ;
                endcase
            end
            if (s_valid && o_s_tready)
                expected_results.push_back(apply_request(s_user, s_data));
            if (o_m_tvalid && m_ready) begin
                got = '{rd: o_m_tdata[7:0], st: o_m_tuser, dh0: o_m_tdata[15:8],
                        dh1: o_m_tdata[23:16]};
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.rd !== want.rd)   note_mismatch("read_data", want.rd, got.rd);
                    if (got.st !== want.st)
                        note_mismatch("status", {7'b0, want.st}, {7'b0, got.st});
                    if (got.dh0 !== want.dh0) note_mismatch("drive_high_port0", want.dh0, got.dh0);
                    if (got.dh1 !== want.dh1) note_mismatch("drive_high_port1", want.dh1, got.dh1);
                end
            end
            if ((cfg_valid && o_cfg_ready) || (s_valid && o_s_tready) || (o_m_tvalid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Result side: stall on a rotating pattern, or hold off entirely on request.
    always @(posedge i_clk) begin
        logic [15:0] next_pat;
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            rx_holding = 1'b1;
            m_ready <= 1'b0;
        end else begin
            rx_holding = 1'b0;
            if (!rx_stall_on) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= rx_pattern[0];
                next_pat = {rx_pattern[0], rx_pattern[15:1]};
                if ($urandom_range(0, 31) == 0)
                    next_pat = 16'($urandom) | 16'h0001;
                rx_pattern <= next_pat;
            end
        end
    end

    function automatic logic [15:0] rand_word();
        return {2'b00, 14'($urandom)};
    endfunction

    function automatic logic [15:0] byte_word(input logic [7:0] d);
        logic [15:0] w;
        w = rand_word();
        w[7:0] = d;
        return w;
    endfunction

    function automatic logic [15:0] pin_word(input logic port, input logic [2:0] pos,
                                             input logic lvl);
        logic [15:0] w;
        w = rand_word();
        w[12:8] = {lvl, pos, port};
        return w;
    endfunction

    function automatic logic [15:0] key_word(input logic pressed);
        logic [15:0] w;
        w = rand_word();
        w[13] = pressed;
        return w;
    endfunction

    // Favor the all-zero and all-one bytes.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [2:0] act, input logic [15:0] word);
        s_valid <= 1'b1;
        s_user  <= act;
        s_data  <= word;
        do @(posedge i_clk); while (!o_s_tready);
        if (act != ACT_SPARE_6 && act != ACT_SPARE_7)
            reqs_sent++;
        if (act == ioexp_pkg::ACT_KEY)
            key_events++;
        if (gaps_on) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(0, 10);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Stop offering requests and wait until every result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic set_key_position(input logic port, input logic [2:0] pos);
        logic [7:0] junk;
        drain_results();
        junk = 8'($urandom);
        cfg_valid <= 1'b1;
        cfg_index <= ioexp_pkg::CFG_KEY_PORT;
        cfg_data  <= {junk[7:1], port};
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_index <= ioexp_pkg::CFG_KEY_BIT;
        cfg_data  <= {junk[4:0], pos};
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        cur_key_port = port;
        cur_key_pos  = pos;
        settings_done++;
    endtask

    task automatic run_mixed_traffic(input int unsigned n);
        int unsigned goal;
        int unsigned pick;
        goal = reqs_sent + n;
        while (reqs_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_item(ioexp_pkg::ACT_START, rand_word());
                send_item(ioexp_pkg::ACT_WRITE, byte_word(8'($urandom)));
                repeat ($urandom_range(1, 4))
                    send_item(ioexp_pkg::ACT_WRITE, byte_word(pick_byte()));
            end else if (pick < 55) begin
                send_item(ioexp_pkg::ACT_START, rand_word());
                if ($urandom_range(0, 1))
                    send_item(ioexp_pkg::ACT_WRITE,
                              byte_word({5'($urandom), 2'b00, cur_key_port}));
                else
                    send_item(ioexp_pkg::ACT_WRITE, byte_word(8'($urandom)));
                repeat ($urandom_range(1, 4)) send_item(ioexp_pkg::ACT_READ, rand_word());
            end else if (pick < 70) begin
                send_item(ioexp_pkg::ACT_KEY, key_word(1'($urandom)));
            end else if (pick < 82) begin
                if ($urandom_range(0, 3) == 0)
                    send_item(ioexp_pkg::ACT_PIN,
                              pin_word(cur_key_port, cur_key_pos, 1'($urandom)));
                else
                    send_item(ioexp_pkg::ACT_PIN,
                              pin_word(1'($urandom), 3'($urandom), 1'($urandom)));
            end else if (pick < 86) begin
                send_item(ioexp_pkg::ACT_RELEASE, rand_word());
            end else if (pick < 91) begin
                // Data or read with no fresh transfer start.
                send_item($urandom_range(0, 1) ? ioexp_pkg::ACT_WRITE : ioexp_pkg::ACT_READ,
                          byte_word(pick_byte()));
            end else if (pick < 94) begin
                send_item(ioexp_pkg::ACT_START, rand_word());
            end else begin
                send_item($urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7, rand_word());
            end
        end
    endtask

    // Walk all eight registers from their reset values, wrapping the pointer.
    task automatic test_register_map();
        send_item(ioexp_pkg::ACT_START, rand_word());
        send_item(ioexp_pkg::ACT_WRITE, byte_word(8'hF8));
        repeat (8) send_item(ioexp_pkg::ACT_READ, rand_word());
    endtask

    // Pointer byte with upper bits set, invalid input writes, extreme data and pins.
    task automatic test_writes_and_pins();
        send_item(ioexp_pkg::ACT_START, rand_word());
        send_item(ioexp_pkg::ACT_WRITE, byte_word(8'hFF));
        send_item(ioexp_pkg::ACT_WRITE, byte_word(8'h00));
        send_item(ioexp_pkg::ACT_WRITE, byte_word(8'hA5));
        send_item(ioexp_pkg::ACT_WRITE, byte_word(8'h5A));
        send_item(ioexp_pkg::ACT_WRITE, byte_word(8'h00));
        send_item(ioexp_pkg::ACT_PIN, pin_word(1'b1, 3'd7, 1'b0));
        send_item(ioexp_pkg::ACT_PIN, pin_word(1'b0, 3'd0, 1'b1));
    endtask

    // Press, deferred release dropped by a second press, key read, then a direct release.
    task automatic test_key_latch();
        send_item(ioexp_pkg::ACT_KEY, key_word(1'b1));
        send_item(ioexp_pkg::ACT_KEY, key_word(1'b0));
        send_item(ioexp_pkg::ACT_KEY, key_word(1'b1));
        send_item(ioexp_pkg::ACT_START, rand_word());
        send_item(ioexp_pkg::ACT_WRITE, byte_word(8'h00));
        send_item(ioexp_pkg::ACT_READ, rand_word());
        send_item(ioexp_pkg::ACT_KEY, key_word(1'b0));
        send_item(ioexp_pkg::ACT_RELEASE, rand_word());
        send_item(ACT_SPARE_6, rand_word());
        send_item(ACT_SPARE_7, rand_word());
    endtask

    // Random traffic under several key positions and pacing modes.
    task automatic test_key_positions();
        logic       ports [6];
        logic [2:0] spots [6];
        ports = '{1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom), 1'($urandom)};
        spots = '{3'd0, 3'd7, 3'd7, 3'd0, 3'($urandom), 3'($urandom)};
        for (int i = 0; i < 6; i++) begin
            set_key_position(ports[i], spots[i]);
            gaps_on     = (i != 0) && ($urandom_range(0, 3) != 0);
            rx_stall_on = (i != 0) && ($urandom_range(0, 3) != 0);
            run_mixed_traffic(58);
        end
    endtask

    // Hold the result side off long enough that the block stops taking requests.
    task automatic test_backpressure();
        drain_results();
        gaps_on = 1'b0;
        rx_stall_on = 1'b0;
        rx_hold_req = 80;
        while (!rx_holding) @(posedge i_clk);
        run_mixed_traffic(30);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_register_map();
        test_writes_and_pins();
        test_key_latch();
        test_key_positions();
        test_backpressure();
        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d requests (%0d key events) and checked %0d results",
                 reqs_sent, key_events, results_checked);
        $display("Key moved through %0d positions; sender gaps, receiver stalls, one long hold",
                 settings_done);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
